FILE: src/itda_pkg.sv
package itda_pkg;

  localparam int CODE_W = 6;
  localparam logic [CODE_W-1:0] CHAR_ZERO  = 6'd48;
  localparam logic [CODE_W-1:0] CHAR_MINUS = 6'd45;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONVERT,
    ST_SKIP,
    ST_SIGN,
    ST_DIGIT
  } state_t;

  typedef struct packed {
    logic load;
    logic dabble;
    logic shift_digit;
    logic emit_sign;
  } dp_cmd_t;

  typedef struct packed {
    logic bit_last;
    logic top_zero;
    logic digit_last;
    logic negative;
  } dp_status_t;

endpackage

FILE: src/integer_to_decimal_ascii.sv
// The item is taken in idle; a serial double-dabble loop then shifts and adjusts once per
// data bit, leading zero digits are dropped (the final digit always stays), an optional
// minus sign is offered, and one character per remaining digit is offered under m_tready.
// No new item is taken until the final character of the current one is accepted.
// Synchronous active-high reset returns the controller to idle with no item pending.
module integer_to_decimal_ascii
  import itda_pkg::*;
#(
  parameter int DATA_WIDTH = 32
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  input  logic [((DATA_WIDTH + 7) / 8) * 8-1:0] s_tdata,  // value
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  output logic [7:0]                            m_tdata,  // char_code, zero fill
  output logic                                  m_tlast
);

  dp_cmd_t           cmd;
  dp_status_t        status;
  logic [CODE_W-1:0] char_code;

  itda_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_last  (m_tlast),
    .status    (status),
    .cmd       (cmd)
  );

  itda_dp #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk       (clk),
    .value     (s_tdata[DATA_WIDTH-1:0]),
    .cmd       (cmd),
    .status    (status),
    .char_code (char_code)
  );

  assign m_tdata = {2'b00, char_code};

endmodule

FILE: src/itda_dp.sv
module itda_dp
  import itda_pkg::*;
#(
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  logic [DATA_WIDTH-1:0] value,
  input  dp_cmd_t               cmd,
  output dp_status_t            status,
  output logic [CODE_W-1:0]     char_code
);

  // Decimal digits needed for any DATA_WIDTH-bit magnitude (1233/4096 ~ log10 2).
  localparam int NDIG = ((DATA_WIDTH * 1233) >> 12) + 1;
  localparam int BCD_W = NDIG * 4;
  localparam int BW = $clog2(DATA_WIDTH);
  localparam int CW = $clog2(NDIG + 1);

  logic [DATA_WIDTH-1:0] mag;
  logic [BCD_W-1:0]      bcd;
  logic                  neg;
  logic [BW-1:0]         bitcnt;
  logic [CW-1:0]         digcnt;

  logic [BCD_W-1:0]      bcd_adj;
  logic [3:0]            top_digit;

  // Add-3 correction on every BCD digit ahead of the shift.
  always_comb begin
    logic [3:0] nib;
    bcd_adj = '0;
    for (int i = 0; i < NDIG; i++) begin
      nib = bcd[4*i +: 4];
      bcd_adj[4*i +: 4] = (nib >= 4'd5) ? nib + 4'd3 : nib;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      neg    <= value[DATA_WIDTH-1];
      // Unsigned negate, so the most negative value gives 2^(DATA_WIDTH-1).
      mag    <= value[DATA_WIDTH-1] ? (~value + 1'b1) : value;
      bcd    <= '0;
      bitcnt <= BW'(DATA_WIDTH - 1);
      digcnt <= CW'(NDIG);
    end else if (cmd.dabble) begin
      bcd    <= {bcd_adj[BCD_W-2:0], mag[DATA_WIDTH-1]};
      mag    <= {mag[DATA_WIDTH-2:0], 1'b0};
      bitcnt <= bitcnt - 1'b1;
    end else if (cmd.shift_digit) begin
      bcd    <= {bcd[BCD_W-5:0], 4'd0};
      digcnt <= digcnt - 1'b1;
    end
  end

  assign top_digit = bcd[BCD_W-1 -: 4];

  assign status.bit_last   = (bitcnt == '0);
  assign status.top_zero   = (top_digit == 4'd0);
  assign status.digit_last = (digcnt == CW'(1));
  assign status.negative   = neg;

  assign char_code = cmd.emit_sign ? CHAR_MINUS : (CHAR_ZERO + {2'b00, top_digit});

endmodule

FILE: src/itda_ctrl.sv
module itda_ctrl
  import itda_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_last,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_CONVERT;
      end
      ST_CONVERT: begin
        if (status.bit_last) state_next = ST_SKIP;
      end
      ST_SKIP: begin
        // Leading zeros are dropped, but the final digit always stays.
        if (!(status.top_zero && !status.digit_last)) begin
          state_next = status.negative ? ST_SIGN : ST_DIGIT;
        end
      end
      ST_SIGN: begin
        if (out_ready) state_next = ST_DIGIT;
      end
      ST_DIGIT: begin
        if (out_ready && status.digit_last) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    out_last  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_CONVERT: begin
        cmd.dabble = 1'b1;
      end
      ST_SKIP: begin
        cmd.shift_digit = status.top_zero && !status.digit_last;
      end
      ST_SIGN: begin
        out_valid     = 1'b1;
        cmd.emit_sign = 1'b1;
      end
      ST_DIGIT: begin
        out_valid       = 1'b1;
        out_last        = status.digit_last;
        cmd.shift_digit = out_ready;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

FILE: src/itda_checker.sv
module itda_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tlast
);

  // One number at a time: no new item is taken while characters are offered.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("input taken while output pending");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled output changed");

  a_char_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata == 8'd45) ||
                 ((m_tdata >= 8'd48) && (m_tdata <= 8'd57)))
    else $error("character out of range");

  a_sign_not_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata == 8'd45) |-> !m_tlast)
    else $error("minus sign marked last");

  a_ready_after_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && m_tlast |=> s_tready && !m_tvalid)
    else $error("block not idle after final character");

endmodule

bind integer_to_decimal_ascii itda_checker u_itda_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
